FILE: hw/rtl/expression_token_lexer_core_defines.svh
// ---------------------------------------------------------------------------
// Expression token lexer assertion macros
// Concurrent assertion helpers shared by the lexer RTL files.
// ---------------------------------------------------------------------------
`ifndef EXPRESSION_TOKEN_LEXER_CORE_DEFINES_SVH
`define EXPRESSION_TOKEN_LEXER_CORE_DEFINES_SVH

`ifndef SYNTH
// Property that must hold at every clock edge outside reset.
`define ETL_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error(msg);
// Same-cycle implication.
`define ETL_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define ETL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ETL_ASSERT(label, clk, rst_n, prop, msg)
`define ETL_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define ETL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: hw/rtl/etl_pkg.sv
// ---------------------------------------------------------------------------
// Expression token lexer package
// Token codes, character constants and record types shared by the lexer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package etl_pkg;

  typedef enum logic [3:0] {
    KIND_IDENT  = 4'd0,
    KIND_ASSERT = 4'd1,
    KIND_NUMBER = 4'd2,
    KIND_OP     = 4'd3,
    KIND_ASSIGN = 4'd4,
    KIND_LPAREN = 4'd5,
    KIND_RPAREN = 4'd6,
    KIND_EOF    = 4'd7,
    KIND_ERROR  = 4'd8
  } token_kind_e;

  typedef enum logic [2:0] {
    OP_PLUS  = 3'd0,
    OP_MINUS = 3'd1,
    OP_STAR  = 3'd2,
    OP_SLASH = 3'd3,
    OP_EQEQ  = 3'd4
  } op_code_e;

  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  // Keyword "assert" is six characters long.
  localparam logic [2:0] KW_LEN = 3'd6;

  localparam logic [15:0] LEN_MAX = 16'hFFFF;

  typedef struct packed {
    token_kind_e kind;
    op_code_e    op;
    logic [15:0] line;
    logic [15:0] column;
    logic [15:0] length;
    logic        last;
  } result_t;

  // Up to two records produced by one accepted text item.
  typedef struct packed {
    logic [1:0] count;
    result_t    rec0;
    result_t    rec1;
  } push_t;

  function automatic logic [7:0] kw_char(input logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0:    ch = 8'h61;
      3'd1:    ch = 8'h73;
      3'd2:    ch = 8'h73;
      3'd3:    ch = 8'h65;
      3'd4:    ch = 8'h72;
      3'd5:    ch = 8'h74;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic result_t make_rec(input token_kind_e kind, input op_code_e op,
                                       input logic [15:0] line, input logic [15:0] column,
                                       input logic [15:0] length);
    result_t r;
    r.kind   = kind;
    r.op     = op;
    r.line   = line;
    r.column = column;
    r.length = length;
    r.last   = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/etl_stream_if.sv
// ---------------------------------------------------------------------------
// Expression token lexer channels
// Valid/ready interfaces for the text input and the token output.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface etl_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface etl_token_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [2:0]  operator_code;
  logic [15:0] token_line;
  logic [15:0] token_column;
  logic [15:0] token_length;
  logic        last_of_run;

  modport source (output valid, output token_kind, output operator_code,
                  output token_line, output token_column, output token_length,
                  output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input operator_code,
                  input token_line, input token_column, input token_length,
                  input last_of_run, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/etl_scanner.sv
// ---------------------------------------------------------------------------
// Expression token lexer scanner
// Scan state, counters and token record generation for one accepted byte per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "expression_token_lexer_core_defines.svh"

module etl_scanner #(
  parameter int LINE_WIDTH   = 16,
  parameter int COLUMN_WIDTH = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          accept_i,
  input  wire logic [7:0]    text_byte_i,
  input  wire logic          end_of_text_i,
  output etl_pkg::push_t     push_o
);

  localparam logic [2:0] MODE_IDLE   = 3'd0;
  localparam logic [2:0] MODE_IDENT  = 3'd1;
  localparam logic [2:0] MODE_NUMBER = 3'd2;
  localparam logic [2:0] MODE_EQ     = 3'd3;
  localparam logic [2:0] MODE_HALT   = 3'd4;

  localparam logic [LINE_WIDTH-1:0]   LINE_MAX = {LINE_WIDTH{1'b1}};
  localparam logic [COLUMN_WIDTH-1:0] COL_MAX  = {COLUMN_WIDTH{1'b1}};
  localparam logic [LINE_WIDTH-1:0]   LINE_ONE = LINE_WIDTH'(1);
  localparam logic [COLUMN_WIDTH-1:0] COL_ONE  = COLUMN_WIDTH'(1);

  logic [2:0]              mode_q, mode_d;
  logic [2:0]              kw_idx_q, kw_idx_d;
  logic                    kw_ok_q, kw_ok_d;
  logic [COLUMN_WIDTH-1:0] start_col_q, start_col_d;
  logic [15:0]             run_len_q, run_len_d;
  logic [LINE_WIDTH-1:0]   line_q, line_d;
  logic [COLUMN_WIDTH-1:0] col_q, col_d;

  logic [31:0] line_ext, col_ext, start_ext;
  logic [15:0] line16, col16, start16;
  logic [COLUMN_WIDTH-1:0] col_inc;
  logic [15:0]             run_inc;
  logic        alpha, digit, white, is_op, kw_start;
  logic        flush_v, use_flush, char_v;
  etl_pkg::result_t flush_rec, char_rec;
  etl_pkg::op_code_e op_sel;

  // Reported positions are the low 16 bits of the counters.
  assign line_ext  = 32'(line_q);
  assign col_ext   = 32'(col_q);
  assign start_ext = 32'(start_col_q);
  assign line16    = line_ext[15:0];
  assign col16     = col_ext[15:0];
  assign start16   = start_ext[15:0];

  assign col_inc = (col_q < COL_MAX) ? col_q + COL_ONE : col_q;
  assign run_inc = (run_len_q < etl_pkg::LEN_MAX) ? run_len_q + 16'd1 : run_len_q;

  assign alpha = ((text_byte_i >= 8'h61) && (text_byte_i <= 8'h7A)) ||
                 ((text_byte_i >= 8'h41) && (text_byte_i <= 8'h5A));
  assign digit = (text_byte_i >= 8'h30) && (text_byte_i <= 8'h39);
  assign white = (text_byte_i == etl_pkg::CH_SPACE) || (text_byte_i == etl_pkg::CH_TAB) ||
                 (text_byte_i == etl_pkg::CH_VT) || (text_byte_i == etl_pkg::CH_FF) ||
                 (text_byte_i == etl_pkg::CH_CR);
  assign is_op = (text_byte_i == etl_pkg::CH_PLUS) || (text_byte_i == etl_pkg::CH_MINUS) ||
                 (text_byte_i == etl_pkg::CH_STAR) || (text_byte_i == etl_pkg::CH_SLASH);
  assign kw_start = (text_byte_i == etl_pkg::kw_char(3'd0));

  always_comb begin
    priority if (text_byte_i == etl_pkg::CH_PLUS) begin
      op_sel = etl_pkg::OP_PLUS;
    end else if (text_byte_i == etl_pkg::CH_MINUS) begin
      op_sel = etl_pkg::OP_MINUS;
    end else if (text_byte_i == etl_pkg::CH_STAR) begin
      op_sel = etl_pkg::OP_STAR;
    end else begin
      op_sel = etl_pkg::OP_SLASH;
    end
  end

  // The record a pending token would give if it ended now.
  always_comb begin
    flush_v   = 1'b0;
    flush_rec = etl_pkg::make_rec(etl_pkg::KIND_IDENT, etl_pkg::OP_PLUS, line16,
                                  start16, run_len_q);
    unique case (mode_q)
      MODE_IDENT: begin
        flush_v = 1'b1;
        if (kw_ok_q && (kw_idx_q == etl_pkg::KW_LEN)) begin
          flush_rec.kind = etl_pkg::KIND_ASSERT;
        end
      end
      MODE_NUMBER: begin
        flush_v        = 1'b1;
        flush_rec.kind = etl_pkg::KIND_NUMBER;
      end
      MODE_EQ: begin
        flush_v          = 1'b1;
        flush_rec.kind   = etl_pkg::KIND_ASSIGN;
        flush_rec.length = 16'd1;
      end
      default: flush_v = 1'b0;
    endcase
  end

  always_comb begin
    mode_d      = mode_q;
    kw_idx_d    = kw_idx_q;
    kw_ok_d     = kw_ok_q;
    start_col_d = start_col_q;
    run_len_d   = run_len_q;
    line_d      = line_q;
    col_d       = col_q;
    use_flush   = 1'b0;
    char_v      = 1'b0;
    char_rec    = etl_pkg::make_rec(etl_pkg::KIND_EOF, etl_pkg::OP_PLUS, line16, col16,
                                    16'd0);

    if (accept_i && (mode_q != MODE_HALT)) begin
      priority if (end_of_text_i) begin
        use_flush = flush_v;
        char_v    = 1'b1;
        mode_d    = MODE_HALT;
      end else if ((mode_q == MODE_IDENT) && (alpha || digit)) begin
        if (kw_ok_q && (kw_idx_q < etl_pkg::KW_LEN) &&
            (text_byte_i == etl_pkg::kw_char(kw_idx_q))) begin
          kw_idx_d = kw_idx_q + 3'd1;
        end else begin
          kw_ok_d = 1'b0;
        end
        run_len_d = run_inc;
        col_d     = col_inc;
      end else if ((mode_q == MODE_NUMBER) && digit) begin
        run_len_d = run_inc;
        col_d     = col_inc;
      end else if ((mode_q == MODE_EQ) && (text_byte_i == etl_pkg::CH_EQUAL)) begin
        char_v   = 1'b1;
        char_rec = etl_pkg::make_rec(etl_pkg::KIND_OP, etl_pkg::OP_EQEQ, line16, start16,
                                     16'd2);
        col_d    = col_inc;
        mode_d   = MODE_IDLE;
      end else begin
        // The byte ends any pending token and is then handled on its own.
        use_flush = flush_v;
        mode_d    = MODE_IDLE;
        priority if (text_byte_i == etl_pkg::CH_NL) begin
          line_d = (line_q < LINE_MAX) ? line_q + LINE_ONE : line_q;
          col_d  = COL_ONE;
        end else if (white) begin
          col_d = col_inc;
        end else if (alpha || digit) begin
          mode_d      = alpha ? MODE_IDENT : MODE_NUMBER;
          start_col_d = col_q;
          run_len_d   = 16'd1;
          kw_idx_d    = kw_start ? 3'd1 : 3'd0;
          kw_ok_d     = kw_start;
          col_d       = col_inc;
        end else if (is_op) begin
          char_v   = 1'b1;
          char_rec = etl_pkg::make_rec(etl_pkg::KIND_OP, op_sel, line16, col16, 16'd1);
          col_d    = col_inc;
        end else if (text_byte_i == etl_pkg::CH_EQUAL) begin
          mode_d      = MODE_EQ;
          start_col_d = col_q;
          col_d       = col_inc;
        end else if (text_byte_i == etl_pkg::CH_LPAREN) begin
          char_v   = 1'b1;
          char_rec = etl_pkg::make_rec(etl_pkg::KIND_LPAREN, etl_pkg::OP_PLUS, line16,
                                       col16, 16'd1);
          col_d    = col_inc;
        end else if (text_byte_i == etl_pkg::CH_RPAREN) begin
          char_v   = 1'b1;
          char_rec = etl_pkg::make_rec(etl_pkg::KIND_RPAREN, etl_pkg::OP_PLUS, line16,
                                       col16, 16'd1);
          col_d    = col_inc;
        end else begin
          char_v   = 1'b1;
          char_rec = etl_pkg::make_rec(etl_pkg::KIND_ERROR, etl_pkg::OP_PLUS, line16,
                                       col16, 16'd0);
          mode_d   = MODE_HALT;
        end
      end
    end
  end

  // Pack the records in emission order and mark the final one.
  always_comb begin
    push_o.count = 2'd0;
    push_o.rec0  = flush_rec;
    push_o.rec1  = char_rec;
    push_o.rec1.last = 1'b1;
    if (use_flush && char_v) begin
      push_o.count = 2'd2;
    end else if (use_flush) begin
      push_o.count     = 2'd1;
      push_o.rec0.last = 1'b1;
    end else if (char_v) begin
      push_o.count = 2'd1;
      push_o.rec0  = char_rec;
      push_o.rec0.last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      kw_idx_q    <= 3'd0;
      kw_ok_q     <= 1'b1;
      start_col_q <= COL_ONE;
      run_len_q   <= 16'd0;
      line_q      <= LINE_ONE;
      col_q       <= COL_ONE;
    end else begin
      mode_q      <= mode_d;
      kw_idx_q    <= kw_idx_d;
      kw_ok_q     <= kw_ok_d;
      start_col_q <= start_col_d;
      run_len_q   <= run_len_d;
      line_q      <= line_d;
      col_q       <= col_d;
    end
  end

  `ETL_ASSERT_NEXT(a_halt_sticky, clk_i, rst_ni, mode_q == MODE_HALT, mode_q == MODE_HALT, "scanner left the halted mode")
  `ETL_ASSERT_IMPLY(a_push_needs_accept, clk_i, rst_ni, push_o.count != 2'd0, accept_i, "records pushed without an accepted byte")
  `ETL_ASSERT_IMPLY(a_pair_order, clk_i, rst_ni, push_o.count == 2'd2, !push_o.rec0.last && (push_o.rec1.kind == etl_pkg::KIND_EOF || push_o.rec1.kind == etl_pkg::KIND_ERROR || push_o.rec1.kind == etl_pkg::KIND_OP || push_o.rec1.kind == etl_pkg::KIND_LPAREN || push_o.rec1.kind == etl_pkg::KIND_RPAREN), "two-record push with a bad second record")

endmodule

`default_nettype wire

FILE: hw/rtl/etl_result_fifo.sv
// ---------------------------------------------------------------------------
// Expression token lexer result queue
// Four-entry register queue that takes up to two records per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "expression_token_lexer_core_defines.svh"

module etl_result_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire etl_pkg::push_t push_i,
  output logic                space_o,
  etl_token_if.source         token_o
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  etl_pkg::result_t  entries_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, wr_ptr_nxt;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              pop;
  etl_pkg::result_t  head;

  assign wr_ptr_nxt = wr_ptr_q + PTR_W'(1);
  assign head       = entries_q[rd_ptr_q];
  assign pop        = token_o.valid && token_o.ready;

  // Room for a full pair is required before the next byte is taken.
  assign space_o = (count_q <= CNT_W'(DEPTH - 2));

  assign token_o.valid         = (count_q != '0);
  assign token_o.token_kind    = head.kind;
  assign token_o.operator_code = head.op;
  assign token_o.token_line    = head.line;
  assign token_o.token_column  = head.column;
  assign token_o.token_length  = head.length;
  assign token_o.last_of_run   = head.last;

  always_comb begin
    wr_ptr_d = wr_ptr_q + PTR_W'(push_i.count);
    rd_ptr_d = pop ? rd_ptr_q + PTR_W'(1) : rd_ptr_q;
    count_d  = count_q + CNT_W'(push_i.count) - CNT_W'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      entries_q[wr_ptr_q] <= push_i.rec0;
    end
    if (push_i.count == 2'd2) begin
      entries_q[wr_ptr_nxt] <= push_i.rec1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  `ETL_ASSERT_IMPLY(a_no_overflow, clk_i, rst_ni, push_i.count != 2'd0, space_o, "push without room")
  `ETL_ASSERT(a_ptr_match, clk_i, rst_ni, (wr_ptr_q - rd_ptr_q) == PTR_W'(count_q), "count mismatch")

endmodule

`default_nettype wire

FILE: hw/rtl/expression_token_lexer_core.sv
// A token record enters the result queue when the byte that ends it is accepted.
// Throughput: one text byte per cycle; a byte that closes a pending token and makes
// its own token gives two records, which drain one per cycle while output is ready.
// The input stalls only while the four-entry result queue lacks room for a pair.
// Reset (asynchronous, active low) clears the scan state to line 1, column 1, no
// pending token, and empties the result queue.
// ---------------------------------------------------------------------------
// Expression token lexer core
// Streaming lexer that turns a byte stream into identifier, keyword, number, operator,
// assignment, parenthesis, end and error token records.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module expression_token_lexer_core #(
  parameter int LINE_WIDTH   = 16,
  parameter int COLUMN_WIDTH = 16
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  etl_text_if.sink      text_i,
  etl_token_if.source   token_o
);

  // A byte transfer happens whenever the queue has room for the worst case of
  // two records, so the scanner never needs to hold a byte back.
  logic           space;
  logic           accept;
  etl_pkg::push_t push;

  assign text_i.ready = space;
  assign accept       = text_i.valid && space;

  // The scanner updates its counters and mode on accepted transfers until it halts
  // and hands any finished records to the queue in the same cycle.
  etl_scanner #(
    .LINE_WIDTH   (LINE_WIDTH),
    .COLUMN_WIDTH (COLUMN_WIDTH)
  ) u_scanner (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .text_byte_i   (text_i.text_byte),
    .end_of_text_i (text_i.end_of_text),
    .push_o        (push)
  );

  // The queue registers the records and presents them one transfer at a time.
  etl_result_fifo u_result_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .space_o (space),
    .token_o (token_o)
  );

endmodule

`default_nettype wire

FILE: dv/testbench.sv
// ---------------------------------------------------------------------------
// Expression token lexer testbench
// Feeds byte streams into the lexer and checks every token record against a
// cycle-free model of the scanner. The stimulus covers directed token mixes,
// random text, output backpressure, long tokens and the final halt.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  // The model mirrors the scanner's own modes. Halt is entered on the end
  // marker or on an unexpected byte, and only a reset leaves it.
  typedef enum logic [2:0] {
    SCAN_IDLE,
    SCAN_IDENT,
    SCAN_NUMBER,
    SCAN_EQ,
    SCAN_HALT
  } scan_state_e;

  localparam logic [5:0][7:0] KEYWORD = "assert";
  localparam logic [15:0]     LINE_MAX = 16'hFFFF;
  localparam logic [15:0]     COL_MAX  = 16'hFFFF;

  logic clk_i = 1'b0;
  logic rst_ni;

  etl_text_if  text_if ();
  etl_token_if token_if ();

  expression_token_lexer_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .text_i  (text_if),
    .token_o (token_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Scanner model state.
  scan_state_e scan_state;
  logic [2:0]  kw_index;
  logic        kw_alive;
  logic [15:0] tok_start_col;
  logic [15:0] tok_len;
  logic [15:0] cur_line;
  logic [15:0] cur_col;

  // Token records that the model has produced and the block still owes.
  etl_pkg::result_t tokens_due[$];

  // Run bookkeeping shared by the stimulus, the receiver and the checker.
  bit idling_on       = 1'b1;
  int hold_off_cycles = 0;
  int bytes_sent      = 0;
  int tokens_checked  = 0;
  int mismatch_count  = 0;
  bit ended_on_error  = 1'b0;

  // -------------------------------------------------------------------------
  // Character classes
  // -------------------------------------------------------------------------

  function automatic bit is_letter(input logic [7:0] ch);
    return (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z");
  endfunction

  function automatic bit is_digit_char(input logic [7:0] ch);
    return ch >= "0" && ch <= "9";
  endfunction

  // Blanks move the column on; the newline is handled on its own.
  function automatic bit is_blank(input logic [7:0] ch);
    return ch == etl_pkg::CH_SPACE || ch == etl_pkg::CH_TAB || ch == etl_pkg::CH_VT ||
           ch == etl_pkg::CH_FF || ch == etl_pkg::CH_CR;
  endfunction

  // -------------------------------------------------------------------------
  // Scanner model
  // -------------------------------------------------------------------------

  function automatic void reset_scanner();
    scan_state    = SCAN_IDLE;
    kw_index      = 3'd0;
    kw_alive      = 1'b1;
    tok_start_col = 16'd1;
    tok_len       = 16'd0;
    cur_line      = 16'd1;
    cur_col       = 16'd1;
  endfunction

  // The column sticks at its maximum instead of wrapping.
  function automatic void advance_column();
    if (cur_col != COL_MAX) cur_col++;
  endfunction

  function automatic void extend_run();
    if (tok_len != etl_pkg::LEN_MAX) tok_len++;
  endfunction

  // Follows the identifier against "assert" one character at a time. Once a
  // character fails, or the identifier runs past six characters, the match
  // is lost for good.
  function automatic void track_keyword(input logic [7:0] ch);
    if (kw_alive && kw_index < etl_pkg::KW_LEN && ch == KEYWORD[5 - int'(kw_index)])
      kw_index++;
    else kw_alive = 1'b0;
  endfunction

  function automatic void begin_run(input logic [7:0] ch, input scan_state_e mode);
    scan_state    = mode;
    tok_start_col = cur_col;
    tok_len       = 16'd1;
    kw_index      = 3'd0;
    kw_alive      = 1'b1;
    track_keyword(ch);
    advance_column();
  endfunction

  // Non-operator kinds carry a zero operator code, which is the plus code.
  function automatic etl_pkg::result_t token_at(input etl_pkg::token_kind_e kind,
                                                input etl_pkg::op_code_e op,
                                                input logic [15:0] column,
                                                input logic [15:0] length);
    etl_pkg::result_t rec;
    rec.kind   = kind;
    rec.op     = op;
    rec.line   = cur_line;
    rec.column = column;
    rec.length = length;
    rec.last   = 1'b0;
    return rec;
  endfunction

  // Closes whatever token is pending and reports whether there was one.
  function automatic bit close_pending(output etl_pkg::result_t rec);
    bit has_token;
    has_token = 1'b1;
    case (scan_state)
      SCAN_IDENT:  rec = token_at((kw_alive && kw_index == etl_pkg::KW_LEN) ?
                                  etl_pkg::KIND_ASSERT : etl_pkg::KIND_IDENT,
                                  etl_pkg::OP_PLUS, tok_start_col, tok_len);
      SCAN_NUMBER: rec = token_at(etl_pkg::KIND_NUMBER, etl_pkg::OP_PLUS, tok_start_col,
                                  tok_len);
      SCAN_EQ:     rec = token_at(etl_pkg::KIND_ASSIGN, etl_pkg::OP_PLUS, tok_start_col,
                                  16'd1);
      default:     has_token = 1'b0;
    endcase
    scan_state = SCAN_IDLE;
    return has_token;
  endfunction

  // Runs one accepted text transfer through the model and queues the token
  // records it causes, with the last flag on the final one.
  function automatic void lex_byte(input logic [7:0] ch, input logic eot);
    etl_pkg::result_t batch[$];
    etl_pkg::result_t rec;
    bit               one_char;
    int               n;
    one_char = 1'b0;
    if (scan_state == SCAN_HALT) return;

    if (eot) begin
      if (close_pending(rec)) batch.push_back(rec);
      batch.push_back(token_at(etl_pkg::KIND_EOF, etl_pkg::OP_PLUS, cur_col, 16'd0));
      scan_state = SCAN_HALT;
    end else if (scan_state == SCAN_IDENT && (is_letter(ch) || is_digit_char(ch))) begin
      track_keyword(ch);
      extend_run();
      advance_column();
    end else if (scan_state == SCAN_NUMBER && is_digit_char(ch)) begin
      extend_run();
      advance_column();
    end else if (scan_state == SCAN_EQ && ch == etl_pkg::CH_EQUAL) begin
      batch.push_back(token_at(etl_pkg::KIND_OP, etl_pkg::OP_EQEQ, tok_start_col, 16'd2));
      advance_column();
      scan_state = SCAN_IDLE;
    end else begin
      if (close_pending(rec)) batch.push_back(rec);
      if (ch == etl_pkg::CH_NL) begin
        if (cur_line != LINE_MAX) cur_line++;
        cur_col = 16'd1;
      end else if (is_blank(ch)) begin
        advance_column();
      end else if (is_letter(ch)) begin
        begin_run(ch, SCAN_IDENT);
      end else if (is_digit_char(ch)) begin
        begin_run(ch, SCAN_NUMBER);
      end else begin
        case (ch)
          etl_pkg::CH_PLUS: begin
            rec      = token_at(etl_pkg::KIND_OP, etl_pkg::OP_PLUS, cur_col, 16'd1);
            one_char = 1'b1;
          end
          etl_pkg::CH_MINUS: begin
            rec      = token_at(etl_pkg::KIND_OP, etl_pkg::OP_MINUS, cur_col, 16'd1);
            one_char = 1'b1;
          end
          etl_pkg::CH_STAR: begin
            rec      = token_at(etl_pkg::KIND_OP, etl_pkg::OP_STAR, cur_col, 16'd1);
            one_char = 1'b1;
          end
          etl_pkg::CH_SLASH: begin
            rec      = token_at(etl_pkg::KIND_OP, etl_pkg::OP_SLASH, cur_col, 16'd1);
            one_char = 1'b1;
          end
          etl_pkg::CH_LPAREN: begin
            rec      = token_at(etl_pkg::KIND_LPAREN, etl_pkg::OP_PLUS, cur_col, 16'd1);
            one_char = 1'b1;
          end
          etl_pkg::CH_RPAREN: begin
            rec      = token_at(etl_pkg::KIND_RPAREN, etl_pkg::OP_PLUS, cur_col, 16'd1);
            one_char = 1'b1;
          end
          etl_pkg::CH_EQUAL: begin
            // Held back until the next byte tells '=' from '=='.
            scan_state    = SCAN_EQ;
            tok_start_col = cur_col;
            advance_column();
          end
          default: begin
            batch.push_back(token_at(etl_pkg::KIND_ERROR, etl_pkg::OP_PLUS, cur_col,
                                     16'd0));
            scan_state = SCAN_HALT;
          end
        endcase
        if (one_char) begin
          batch.push_back(rec);
          advance_column();
        end
      end
    end

    n = batch.size();
    for (int i = 0; i < n; i++) begin
      rec      = batch[i];
      rec.last = (i == n - 1);
      tokens_due.push_back(rec);
    end
  endfunction

  // -------------------------------------------------------------------------
  // Random characters
  // -------------------------------------------------------------------------

  function automatic logic [7:0] random_letter();
    return $urandom_range(0, 1) ? 8'("a" + $urandom_range(0, 25))
                                : 8'("A" + $urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] random_digit();
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] random_alnum();
    return ($urandom_range(0, 2) == 0) ? random_digit() : random_letter();
  endfunction

  function automatic logic [7:0] random_op_char();
    case ($urandom_range(0, 3))
      0:       return etl_pkg::CH_PLUS;
      1:       return etl_pkg::CH_MINUS;
      2:       return etl_pkg::CH_STAR;
      default: return etl_pkg::CH_SLASH;
    endcase
  endfunction

  function automatic logic [7:0] random_blank();
    case ($urandom_range(0, 4))
      0:       return etl_pkg::CH_SPACE;
      1:       return etl_pkg::CH_TAB;
      2:       return etl_pkg::CH_VT;
      3:       return etl_pkg::CH_FF;
      default: return etl_pkg::CH_CR;
    endcase
  endfunction

  // -------------------------------------------------------------------------
  // Sender side
  // -------------------------------------------------------------------------

  // Offers one text transfer and waits for the block to take it. While
  // idling is on, a random burst of empty cycles may come first. Valid is
  // left high after the transfer so back-to-back bytes need no gap; any
  // wait that lets time pass drops it first.
  task automatic send_item(input logic [7:0] ch, input logic eot);
    if (idling_on && $urandom_range(0, 9) == 0) begin
      text_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    text_if.valid       <= 1'b1;
    text_if.text_byte   <= ch;
    text_if.end_of_text <= eot;
    do @(posedge clk_i); while (!text_if.ready);
    lex_byte(ch, eot);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  // The sender stops offering while it waits, so the last byte is not
  // taken a second time.
  task automatic wait_tokens_drained();
    if (tokens_due.size() != 0) begin
      text_if.valid <= 1'b0;
      while (tokens_due.size() != 0) @(posedge clk_i);
    end
  endtask

  // One random lexeme. Fragments are sent back to back without separators,
  // so numbers run into identifiers and '=' runs into '=' on their own.
  task automatic send_fragment();
    int n;
    case ($urandom_range(0, 11))
      0, 1: begin
        send_item(random_letter(), 1'b0);
        repeat ($urandom_range(0, 7)) send_item(random_alnum(), 1'b0);
      end
      2: begin
        // The keyword whole, cut short, or with a tail that spoils it.
        n = $urandom_range(0, 1) ? 6 : $urandom_range(1, 5);
        for (int i = 0; i < n; i++) send_item(KEYWORD[5 - i], 1'b0);
        if ($urandom_range(0, 2) == 0) send_item(random_alnum(), 1'b0);
      end
      3, 4: repeat ($urandom_range(1, 6)) send_item(random_digit(), 1'b0);
      5:    send_item(random_op_char(), 1'b0);
      6:    send_item(etl_pkg::CH_EQUAL, 1'b0);
      7: begin
        send_item(etl_pkg::CH_EQUAL, 1'b0);
        send_item(etl_pkg::CH_EQUAL, 1'b0);
      end
      8:     send_item($urandom_range(0, 1) ? etl_pkg::CH_LPAREN : etl_pkg::CH_RPAREN, 1'b0);
      9, 10: send_item(random_blank(), 1'b0);
      default: send_item(etl_pkg::CH_NL, 1'b0);
    endcase
  endtask

  // A single byte from any class the scanner accepts, with no structure.
  task automatic send_noise();
    case ($urandom_range(0, 6))
      0:       send_item(random_letter(), 1'b0);
      1:       send_item(random_digit(), 1'b0);
      2:       send_item(random_blank(), 1'b0);
      3:       send_item(random_op_char(), 1'b0);
      4:       send_item(etl_pkg::CH_EQUAL, 1'b0);
      5:       send_item($urandom_range(0, 1) ? etl_pkg::CH_LPAREN : etl_pkg::CH_RPAREN, 1'b0);
      default: send_item(etl_pkg::CH_NL, 1'b0);
    endcase
  endtask

  // -------------------------------------------------------------------------
  // Receiver side
  // -------------------------------------------------------------------------

  // Ready is redrawn at every rising edge. A hold-off requested by a test
  // is counted down here first; otherwise random stall bursts come in while
  // idling is on.
  initial begin : token_receiver
    int stall_left;
    stall_left     = 0;
    token_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_cycles > 0) begin
        token_if.ready <= 1'b0;
        hold_off_cycles--;
      end else if (stall_left > 0) begin
        token_if.ready <= 1'b0;
        stall_left--;
      end else if (idling_on && $urandom_range(0, 9) == 0) begin
        token_if.ready <= 1'b0;
        stall_left = $urandom_range(1, 12) - 1;
      end else begin
        token_if.ready <= 1'b1;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Checking
  // -------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("MISMATCH @%0d ns: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("token %0d %s: got %0d, expected %0d",
                                tokens_checked, name, got, want));
  endtask

  // Every token transfer is taken against the oldest record the model owes.
  always @(posedge clk_i) begin : token_checker
    etl_pkg::result_t want;
    if (rst_ni && token_if.valid && token_if.ready) begin
      if (tokens_due.size() == 0) begin
        report_mismatch($sformatf("token transfer kind %0d line %0d column %0d with none due",
                                  token_if.token_kind, token_if.token_line,
                                  token_if.token_column));
      end else begin
        want = tokens_due.pop_front();
        check_field("kind", 16'(token_if.token_kind), 16'(want.kind));
        check_field("operator", 16'(token_if.operator_code), 16'(want.op));
        check_field("line", token_if.token_line, want.line);
        check_field("column", token_if.token_column, want.column);
        check_field("length", token_if.token_length, want.length);
        check_field("last", 16'(token_if.last_of_run), 16'(want.last));
      end
      tokens_checked++;
    end
  end

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------

  // Identifier with a digit, '=' closed by '(' (two records from one byte),
  // a number that runs into letters, '==', and all four operators.
  task automatic test_operators_and_lookahead();
    send_text("x1=(42ab==7)+-*/");
    wait_tokens_drained();
  endtask

  // The keyword against a longer identifier, every blank character, a
  // number closed by a newline, and a lone '=' closed by a newline.
  task automatic test_keyword_and_blanks();
    send_text("assert asserts");
    send_item(etl_pkg::CH_TAB, 1'b0);
    send_item(etl_pkg::CH_VT, 1'b0);
    send_item(etl_pkg::CH_FF, 1'b0);
    send_item(etl_pkg::CH_CR, 1'b0);
    send_text("9");
    send_item(etl_pkg::CH_NL, 1'b0);
    send_text("=");
    send_item(etl_pkg::CH_NL, 1'b0);
    wait_tokens_drained();
  endtask

  // Mostly well-formed lexemes with random content, with some loose bytes in
  // between. Idling is switched on and off in stretches, and now and then
  // the sender waits for the output to run dry.
  task automatic test_random_text();
    int goal;
    goal = bytes_sent + 850;
    while (bytes_sent < goal) begin
      if ($urandom_range(0, 39) == 0) idling_on = ($urandom_range(0, 2) != 0);
      if ($urandom_range(0, 59) == 0) wait_tokens_drained();
      if ($urandom_range(0, 4) == 0) send_noise();
      else send_fragment();
    end
    idling_on = 1'b1;
    wait_tokens_drained();
  endtask

  // The receiver holds off for a long stretch while the sender keeps
  // offering bytes, so the result queue fills and the input stalls. The
  // second burst makes every '*' close an identifier too, so each '*'
  // pushes a pair.
  task automatic test_output_backpressure();
    hold_off_cycles = 200;
    repeat (15) begin
      send_item(etl_pkg::CH_LPAREN, 1'b0);
      send_item(random_op_char(), 1'b0);
      send_item(etl_pkg::CH_RPAREN, 1'b0);
      send_item(etl_pkg::CH_SPACE, 1'b0);
    end
    wait_tokens_drained();
    hold_off_cycles = 120;
    repeat (20) begin
      send_item(random_letter(), 1'b0);
      send_item(etl_pkg::CH_STAR, 1'b0);
    end
    wait_tokens_drained();
  endtask

  // A long identifier closed by a blank, and a long number closed by a byte that
  // makes a token of its own, so the start column and length of a long run are seen.
  task automatic test_long_tokens();
    send_item(etl_pkg::CH_NL, 1'b0);
    send_item(random_letter(), 1'b0);
    repeat (40) send_item(random_alnum(), 1'b0);
    send_item(etl_pkg::CH_SPACE, 1'b0);
    send_item(random_op_char(), 1'b0);
    send_item(etl_pkg::CH_NL, 1'b0);
    repeat (30) send_item(random_digit(), 1'b0);
    send_item(etl_pkg::CH_LPAREN, 1'b0);
    send_item(etl_pkg::CH_NL, 1'b0);
    wait_tokens_drained();
  endtask

  // The run can end only once, so the seed picks the way it ends: an
  // unexpected byte or the end marker, either one after a random pending
  // token or none. Everything sent afterwards, including another end marker and
  // bytes with the top bit set, must be ignored.
  task automatic test_end_of_text();
    logic [7:0] bad;
    ended_on_error = ($urandom_range(0, 1) != 0);
    case ($urandom_range(0, 3))
      0:       send_text("ab");
      1:       send_text("12");
      2:       send_item(etl_pkg::CH_EQUAL, 1'b0);
      default: ;
    endcase
    if (ended_on_error) begin
      do bad = 8'($urandom_range(0, 255));
      while (is_letter(bad) || is_digit_char(bad) || is_blank(bad) ||
             bad == etl_pkg::CH_NL || bad == etl_pkg::CH_PLUS ||
             bad == etl_pkg::CH_MINUS || bad == etl_pkg::CH_STAR ||
             bad == etl_pkg::CH_SLASH || bad == etl_pkg::CH_EQUAL ||
             bad == etl_pkg::CH_LPAREN || bad == etl_pkg::CH_RPAREN);
      send_item(bad, 1'b0);
    end else begin
      // The byte that comes with the end marker carries no meaning.
      send_item(8'($urandom_range(0, 255)), 1'b1);
    end
    send_item(8'hFF, 1'b1);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_text("x+1");
  endtask

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------

  initial begin
    text_if.valid       = 1'b0;
    text_if.text_byte   = 8'h00;
    text_if.end_of_text = 1'b0;
    rst_ni              = 1'b0;
    reset_scanner();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_operators_and_lookahead();
    test_keyword_and_blanks();
    test_random_text();
    test_output_backpressure();

    // The long tokens and the ending go at full rate on both sides.
    idling_on = 1'b0;
    test_long_tokens();
    test_end_of_text();

    text_if.valid <= 1'b0;
    for (int i = 0; i < 5000 && tokens_due.size() != 0; i++) @(posedge clk_i);
    // The run goes on after the queue drains so that a stray record after the last one is caught.
    repeat (16) @(posedge clk_i);
    if (tokens_due.size() != 0)
      report_mismatch($sformatf("%0d token records never arrived", tokens_due.size()));

    $display("Run covered %0d text bytes and %0d token records: keywords, operators,",
             bytes_sent, tokens_checked);
    $display("'=' lookahead, backpressure, long tokens and an %s ending.",
             ended_on_error ? "unexpected-byte" : "end-marker");
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run, which stays well under
  // half a millisecond.
  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/etl_pkg.sv
hw/rtl/etl_stream_if.sv
hw/rtl/etl_scanner.sv
hw/rtl/etl_result_fifo.sv
hw/rtl/expression_token_lexer_core.sv
dv/testbench.sv
